### sv/swqt_pkg.sv
// Shared types and constants for the semaphore wait queue table.
`default_nettype none

package swqt_pkg;

  localparam int NUM_PROCS = 16;
  localparam int NUM_SEMS  = 16;
  localparam int ADDR_BITS = 32;
  localparam int PID_W     = $clog2(NUM_PROCS);
  localparam int SLOT_W    = $clog2(NUM_SEMS);

  typedef enum logic [1:0] {
    CMD_BLOCK  = 2'd0,
    CMD_WAKE   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_PEEK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]           command;
    logic [ADDR_BITS-1:0] sem_addr;
    logic [PID_W-1:0]     proc_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             proc_valid;
    logic [PID_W-1:0] proc_out;
  } out_item_t;

  // key lookup result
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              free_ok;
    logic [SLOT_W-1:0] free_slot;
  } match_t;

endpackage

`default_nettype wire

### sv/swqt_match.sv
// Parallel key compare and lowest-free-slot search over the descriptor table.
`default_nettype none

module swqt_match
  import swqt_pkg::*;
(
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [ADDR_BITS-1:0] keys [NUM_SEMS],
  input  wire logic [NUM_SEMS-1:0]  used,
  output match_t                    res
);

  always_comb begin
    res = '0;
    // scan downward so the lowest index wins
    for (int s = NUM_SEMS - 1; s >= 0; s--) begin
      if (used[s] && keys[s] == addr) begin
        res.hit      = 1'b1;
        res.hit_slot = SLOT_W'(s);
      end
      if (!used[s]) begin
        res.free_ok   = 1'b1;
        res.free_slot = SLOT_W'(s);
      end
    end
  end

endmodule

`default_nettype wire

### sv/semaphore_wait_queue_table.sv
// Top level: active semaphore table with per-semaphore FIFO of blocked processes.
`default_nettype none

// One command is taken per clock whenever busy is low; busy is high only while
// reset is asserted. A command is captured in the input register at the
// transfer edge, executed against the table in the following cycle (key match
// over all descriptors, then the linked-list pointer update). Its single result
// is registered on out_data with out_strobe high for exactly one cycle, the
// cycle after execution, and it is taken at the edge that ends that cycle.
// The receiver cannot stall: the result is gone after that cycle, so a consumer
// must sample every strobe. Back-to-back commands see each other's table updates
// in order, so the sustained rate is one command per clock. Of the table, reset
// clears only the used and blocked marks; no clearing pass is run.

module semaphore_wait_queue_table
  import swqt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  output logic           out_strobe,
  output out_item_t      out_data
);

  // input register
  logic     in_valid_r;
  in_item_t in_q_r;

  // table state
  logic [ADDR_BITS-1:0] sem_key_r       [NUM_SEMS];
  logic [NUM_SEMS-1:0]  sem_used_r;
  logic [PID_W-1:0]     queue_head_r    [NUM_SEMS];
  logic [PID_W-1:0]     queue_tail_r    [NUM_SEMS];
  logic [PID_W-1:0]     proc_next_r     [NUM_PROCS];
  logic [PID_W-1:0]     proc_prev_r     [NUM_PROCS];
  logic [NUM_PROCS-1:0] proc_blocked_r;
  logic [SLOT_W-1:0]    proc_sem_slot_r [NUM_PROCS];

  // result register
  logic      out_strobe_r;
  out_item_t out_data_r;
  out_item_t out_nxt;

  cmd_t              cmd;
  logic              bad_addr;
  logic              pid_blocked;
  match_t            mt;
  logic [SLOT_W-1:0] sel;
  logic [PID_W-1:0]  head, tail, up, up_next, up_prev;
  logic              do_block, block_new, do_unlink;

  assign busy = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_q_r <= in_data;
    end
  end

  swqt_match u_match (
    .addr (in_q_r.sem_addr),
    .keys (sem_key_r),
    .used (sem_used_r),
    .res  (mt)
  );

  // decode and single-pass execution of the registered command
  always_comb begin
    cmd         = cmd_t'(in_q_r.command);
    bad_addr    = (in_q_r.sem_addr == '0) || (&in_q_r.sem_addr);
    pid_blocked = proc_blocked_r[in_q_r.proc_id];

    // remove uses the process's own semaphore, the others the matched key
    sel  = (cmd == CMD_REMOVE) ? proc_sem_slot_r[in_q_r.proc_id] : mt.hit_slot;
    head = queue_head_r[sel];
    tail = queue_tail_r[sel];
    up   = (cmd == CMD_REMOVE) ? in_q_r.proc_id : head;
    up_next = proc_next_r[up];
    up_prev = proc_prev_r[up];

    do_block  = 1'b0;
    block_new = 1'b0;
    do_unlink = 1'b0;
    out_nxt   = '0;

    case (cmd)
      CMD_BLOCK: begin
        if (bad_addr || pid_blocked) begin
          out_nxt.status = ST_BAD;
        end else if (!mt.hit && !mt.free_ok) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.status = ST_OK;
          do_block       = in_valid_r;
          block_new      = !mt.hit;
        end
      end
      CMD_REMOVE: begin
        if (!pid_blocked) begin
          out_nxt.status = ST_BAD;
        end else begin
          out_nxt.status     = ST_OK;
          out_nxt.proc_valid = 1'b1;
          out_nxt.proc_out   = in_q_r.proc_id;
          do_unlink          = in_valid_r;
        end
      end
      CMD_WAKE, CMD_PEEK: begin
        if (bad_addr) begin
          out_nxt.status = ST_BAD;
        end else if (!mt.hit) begin
          out_nxt.status = ST_NOTFOUND;
        end else begin
          out_nxt.status     = ST_OK;
          out_nxt.proc_valid = 1'b1;
          out_nxt.proc_out   = head;
          do_unlink          = in_valid_r && (cmd == CMD_WAKE);
        end
      end
      default: begin
        out_nxt.status = ST_BAD;
      end
    endcase
  end

  // used and blocked marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sem_used_r     <= '0;
      proc_blocked_r <= '0;
    end else begin
      if (do_block) begin
        proc_blocked_r[in_q_r.proc_id] <= 1'b1;
        if (block_new) begin
          sem_used_r[mt.free_slot] <= 1'b1;
        end
      end
      if (do_unlink) begin
        proc_blocked_r[up] <= 1'b0;
        // last waiter leaves: release the descriptor
        if (head == up && tail == up) begin
          sem_used_r[sel] <= 1'b0;
        end
      end
    end
  end

  // keys and list pointers, valid only under a set mark
  always_ff @(posedge clk) begin
    if (do_block) begin
      if (block_new) begin
        sem_key_r[mt.free_slot]    <= in_q_r.sem_addr;
        queue_head_r[mt.free_slot] <= in_q_r.proc_id;
        queue_tail_r[mt.free_slot] <= in_q_r.proc_id;
        proc_sem_slot_r[in_q_r.proc_id] <= mt.free_slot;
      end else begin
        // append behind the current tail
        proc_next_r[tail]               <= in_q_r.proc_id;
        proc_prev_r[in_q_r.proc_id]     <= tail;
        queue_tail_r[mt.hit_slot]       <= in_q_r.proc_id;
        proc_sem_slot_r[in_q_r.proc_id] <= mt.hit_slot;
      end
      proc_next_r[in_q_r.proc_id] <= in_q_r.proc_id;
    end
    if (do_unlink) begin
      if (head == up && tail == up) begin
        // descriptor freed, pointers left stale
      end else if (head == up) begin
        queue_head_r[sel] <= up_next;
      end else if (tail == up) begin
        queue_tail_r[sel] <= up_prev;
      end else begin
        proc_next_r[up_prev] <= up_next;
        proc_prev_r[up_next] <= up_prev;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // a result is only produced for a command executed the cycle before
  a_strobe_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(in_valid_r))
    else $error("result strobe without an executed command");

  a_valid_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_data_r.proc_valid |-> out_data_r.status == ST_OK)
    else $error("process reported with an error status");

  a_no_proc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_data_r.proc_valid |-> out_data_r.proc_out == '0)
    else $error("proc_out nonzero without proc_valid");

  a_unlink_clears: assert property (@(posedge clk) disable iff (!rst_n)
    do_unlink |=> !proc_blocked_r[$past(up)])
    else $error("dequeued process still marked blocked");

  a_block_sets: assert property (@(posedge clk) disable iff (!rst_n)
    do_block |=> proc_blocked_r[$past(in_q_r.proc_id)] && sem_used_r[$past(sel)] ||
                 proc_blocked_r[$past(in_q_r.proc_id)] && $past(block_new))
    else $error("blocked process not recorded");

endmodule

`default_nettype wire

### bench/semaphore_wait_queue_table_test.sv
// Self-checking bench for the semaphore wait queue table: directed and random command traffic.
`default_nettype none

module semaphore_wait_queue_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swqt_pkg::*;

  localparam logic [ADDR_BITS-1:0] ADDR_ALL_ONES = '1;
  localparam logic [ADDR_BITS-1:0] ADDR_LOWEST   = 32'h0000_0001;
  localparam logic [ADDR_BITS-1:0] ADDR_HIGHEST  = 32'hFFFF_FFFE;

  // DUT ports; every input is known from time zero.
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_strobe;
  out_item_t out_data;

  semaphore_wait_queue_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bench-side copy of the descriptor table and the per-process links.
  // Entries other than the used and waiting marks are only read under those marks.
  logic [ADDR_BITS-1:0] key_of_slot [NUM_SEMS];
  bit                   slot_used   [NUM_SEMS];
  logic [PID_W-1:0]     slot_head   [NUM_SEMS];
  logic [PID_W-1:0]     slot_tail   [NUM_SEMS];
  logic [PID_W-1:0]     pid_next    [NUM_PROCS];
  logic [PID_W-1:0]     pid_prev    [NUM_PROCS];
  bit                   pid_waiting [NUM_PROCS];
  logic [SLOT_W-1:0]    pid_slot    [NUM_PROCS];

  out_item_t pending_results [$];   // predicted results, oldest first
  int        error_count = 0;
  int        results_checked = 0;
  int        cmd_count [4] = '{0, 0, 0, 0};
  int        sender_idle_pct = 0;  // chance in 100 of a gap before a command

  initial begin
    for (int i = 0; i < NUM_SEMS; i++) begin
      key_of_slot[i] = '0;
      slot_used[i]   = 1'b0;
      slot_head[i]   = '0;
      slot_tail[i]   = '0;
    end
    for (int i = 0; i < NUM_PROCS; i++) begin
      pid_next[i]    = '0;
      pid_prev[i]    = '0;
      pid_waiting[i] = 1'b0;
      pid_slot[i]    = '0;
    end
  end

  // Associative lookup over the active descriptors; -1 on a miss.
  function automatic int slot_of_key(logic [ADDR_BITS-1:0] key);
    for (int s = 0; s < NUM_SEMS; s++)
      if (slot_used[s] && key_of_slot[s] == key) return s;
    return -1;
  endfunction

  function automatic int lowest_free_slot();
    for (int s = 0; s < NUM_SEMS; s++)
      if (!slot_used[s]) return s;
    return -1;
  endfunction

  // Take process p out of slot s's queue; the descriptor goes away once empty.
  function automatic void drop_from_queue(int s, int p);
    if (slot_head[s] == p && slot_tail[s] == p) begin
      slot_used[s] = 1'b0;
    end else if (slot_head[s] == p) begin
      slot_head[s] = pid_next[p];
    end else if (slot_tail[s] == p) begin
      slot_tail[s] = pid_prev[p];
    end else begin
      pid_next[pid_prev[p]] = pid_next[p];
      pid_prev[pid_next[p]] = pid_prev[p];
    end
    pid_waiting[p] = 1'b0;
  endfunction

  // Applies one command to the bench table and returns the result it must give.
  function automatic out_item_t semaphore_table_update(in_item_t req);
    out_item_t        res;
    cmd_t             cmd;
    int               p;
    int               s;
    bit               key_bad;
    logic [PID_W-1:0] head;
    res     = '0;
    cmd     = cmd_t'(req.command);
    p       = int'(req.proc_id);
    key_bad = (req.sem_addr == '0) || (req.sem_addr == ADDR_ALL_ONES);
    res.status = ST_OK;
    case (cmd)
      CMD_BLOCK: begin
        if (key_bad || p >= NUM_PROCS || pid_waiting[p]) begin
          res.status = ST_BAD;
        end else begin
          s = slot_of_key(req.sem_addr);
          if (s >= 0) begin
            // append behind the current tail
            pid_next[slot_tail[s]] = req.proc_id;
            pid_prev[p]            = slot_tail[s];
            slot_tail[s]           = req.proc_id;
          end else begin
            s = lowest_free_slot();
            if (s < 0) begin
              res.status = ST_FULL;
            end else begin
              slot_used[s]   = 1'b1;
              key_of_slot[s] = req.sem_addr;
              slot_head[s]   = req.proc_id;
              slot_tail[s]   = req.proc_id;
            end
          end
          if (res.status == ST_OK) begin
            pid_waiting[p] = 1'b1;
            pid_slot[p]    = SLOT_W'(s);
            pid_next[p]    = req.proc_id;
          end
        end
      end
      CMD_REMOVE: begin
        // the address is ignored: the process's own semaphore is used
        if (p >= NUM_PROCS || !pid_waiting[p]) begin
          res.status = ST_BAD;
        end else begin
          drop_from_queue(int'(pid_slot[p]), p);
          res.proc_valid = 1'b1;
          res.proc_out   = req.proc_id;
        end
      end
      default: begin
        // wake and peek
        if (key_bad) begin
          res.status = ST_BAD;
        end else begin
          s = slot_of_key(req.sem_addr);
          if (s < 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            head           = slot_head[s];
            res.proc_valid = 1'b1;
            res.proc_out   = head;
            if (cmd == CMD_WAKE) drop_from_queue(s, int'(head));
          end
        end
      end
    endcase
    return res;
  endfunction

  // Result checker and transfer monitor, both on the rising edge. A result
  // trails its transfer through the input and result registers, so checking
  // before predicting in the same edge is safe.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d proc_valid %0d proc_out %0d",
               out_data.status, out_data.proc_valid, out_data.proc_out);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.proc_valid !== want.proc_valid) begin
          $error("proc_valid: expected %0d, got %0d", want.proc_valid, out_data.proc_valid);
          error_count++;
        end
        if (out_data.proc_out !== want.proc_out) begin
          $error("proc_out: expected %0d, got %0d", want.proc_out, out_data.proc_out);
          error_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      pending_results.push_back(semaphore_table_update(in_data));
      cmd_count[in_data.command]++;
    end
  end

  // Drives one command from a falling edge and returns at the falling edge
  // after its transfer. start stays high across back-to-back commands.
  task automatic issue_command(cmd_t cmd, logic [ADDR_BITS-1:0] key, logic [PID_W-1:0] pid);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = '{command: cmd, sem_addr: key, proc_id: pid};
    start   = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Invalid keys on every key-taking command, remove of an idle process,
  // and wake/peek on a semaphore that has no descriptor.
  task automatic test_invalid_keys();
    issue_command(CMD_BLOCK,  '0,            4'd0);
    issue_command(CMD_BLOCK,  ADDR_ALL_ONES, 4'd15);
    issue_command(CMD_WAKE,   ADDR_ALL_ONES, 4'd0);
    issue_command(CMD_PEEK,   '0,            4'd0);
    issue_command(CMD_REMOVE, 32'h5A5A_A5A5, 4'd15);
    issue_command(CMD_PEEK,   32'h0000_1234, 4'd0);
    issue_command(CMD_WAKE,   32'h8000_0000, 4'd0);
  endtask

  // FIFO wake order, double block, and release of the descriptor on empty.
  task automatic test_fifo_order();
    issue_command(CMD_BLOCK, ADDR_HIGHEST, 4'd0);
    issue_command(CMD_BLOCK, ADDR_HIGHEST, 4'd15);
    issue_command(CMD_BLOCK, ADDR_HIGHEST, 4'd0);   // already waiting
    issue_command(CMD_PEEK,  ADDR_HIGHEST, 4'd0);
    issue_command(CMD_WAKE,  ADDR_HIGHEST, 4'd0);
    issue_command(CMD_WAKE,  ADDR_HIGHEST, 4'd0);
    issue_command(CMD_PEEK,  ADDR_HIGHEST, 4'd0);   // descriptor gone
  endtask

  // Remove from the middle, the tail and the head; the address is don't-care.
  task automatic test_remove_anywhere();
    issue_command(CMD_BLOCK,  ADDR_LOWEST,   4'd3);
    issue_command(CMD_BLOCK,  ADDR_LOWEST,   4'd4);
    issue_command(CMD_BLOCK,  ADDR_LOWEST,   4'd5);
    issue_command(CMD_BLOCK,  ADDR_LOWEST,   4'd9);
    issue_command(CMD_REMOVE, '0,            4'd4);
    issue_command(CMD_REMOVE, ADDR_ALL_ONES, 4'd9);
    issue_command(CMD_REMOVE, ADDR_LOWEST,   4'd3);
    issue_command(CMD_WAKE,   ADDR_LOWEST,   4'd0);
    issue_command(CMD_PEEK,   ADDR_LOWEST,   4'd0);
  endtask

  // Mostly picks a process whose waiting mark matches; sometimes any process.
  function automatic logic [PID_W-1:0] pick_pid(bit want_waiting);
    int candidates [$];
    for (int i = 0; i < NUM_PROCS; i++)
      if (pid_waiting[i] == want_waiting) candidates.push_back(i);
    if (candidates.size() != 0 && $urandom_range(99) < 80)
      return PID_W'(candidates[$urandom_range(candidates.size() - 1)]);
    return PID_W'($urandom_range(NUM_PROCS - 1));
  endfunction

  // Random traffic on a small pool of valid keys so queues build up and
  // drain; a few percent are noise commands with invalid or stray keys.
  task automatic test_random_traffic(int idle_pct, int n_items);
    logic [ADDR_BITS-1:0] key_pool [6];
    logic [ADDR_BITS-1:0] key;
    logic [PID_W-1:0]     pid;
    cmd_t                 cmd;
    int                   roll;
    sender_idle_pct = idle_pct;
    key_pool[0] = ADDR_LOWEST;
    key_pool[1] = ADDR_HIGHEST;
    for (int k = 2; k < 6; k++) begin
      do key_pool[k] = $urandom; while (key_pool[k] == '0 || key_pool[k] == ADDR_ALL_ONES);
    end
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      key  = key_pool[$urandom_range(5)];
      pid  = PID_W'($urandom_range(NUM_PROCS - 1));
      if (roll < 40) begin
        cmd = CMD_BLOCK;
        pid = pick_pid(1'b0);
      end else if (roll < 60) begin
        cmd = CMD_WAKE;
      end else if (roll < 78) begin
        cmd = CMD_REMOVE;
        pid = pick_pid(1'b1);
      end else if (roll < 93) begin
        cmd = CMD_PEEK;
      end else begin
        cmd = cmd_t'($urandom_range(3));
        case ($urandom_range(2))
          0:       key = '0;
          1:       key = ADDR_ALL_ONES;
          default: key = $urandom;
        endcase
      end
      issue_command(cmd, key, pid);
    end
  endtask

  // Wait out the outstanding results, then the pipeline depth.
  task automatic drain_results();
    int waited;
    waited = 0;
    while (pending_results.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
  endtask

  initial begin
    // synchronous reset, released on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_invalid_keys();
    test_fifo_order();
    test_remove_anywhere();
    test_random_traffic(0, 240);    // back-to-back transfers
    test_random_traffic(65, 230);   // sender mostly idle
    test_random_traffic(15, 230);   // light idling
    start = 1'b0;
    drain_results();

    $display("Ran %0d commands: %0d block, %0d wake, %0d remove, %0d peek.",
             cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
    $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
